// ----- sv/itsp_pkg.sv -----
// ----------------------------------------------------------------------------
// itsp_pkg
// Shared widths, character codes, register indexes, stage types and the
// month length table for the timestamp parser.
// ----------------------------------------------------------------------------
package itsp_pkg;

	localparam int CHAR_W   = 8;
	localparam int POS_W    = 5;
	localparam int YACC_W   = 14;
	localparam int ACC_W    = 7;
	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [POS_W-1:0] TS_LEN   = 5'd20;
	localparam logic [POS_W-1:0] POS_LAST = 5'd19;
	localparam logic [POS_W-1:0] POS_DASH_A  = 5'd4;
	localparam logic [POS_W-1:0] POS_DASH_B  = 5'd7;
	localparam logic [POS_W-1:0] POS_T       = 5'd10;
	localparam logic [POS_W-1:0] POS_COLON_A = 5'd13;
	localparam logic [POS_W-1:0] POS_COLON_B = 5'd16;
	localparam logic [POS_W-1:0] POS_Z       = 5'd19;

	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_T     = 8'h54;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

	localparam logic [YACC_W-1:0] YEAR_MIN = 14'd2000;
	localparam logic [YACC_W-1:0] YEAR_MAX = 14'd2099;
	localparam logic [ACC_W-1:0]  MONTH_MAX  = 7'd12;
	localparam logic [ACC_W-1:0]  HOUR_MAX   = 7'd23;
	localparam logic [ACC_W-1:0]  MINSEC_MAX = 7'd59;

	localparam logic [CFG_IDX_W-1:0] REG_YEAR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MONTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOUR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MINUTE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND = 3'd5;

	localparam logic [YEAR_W-1:0]   THR_YEAR_RST   = 12'd2026;
	localparam logic [MONTH_W-1:0]  THR_MONTH_RST  = 4'd3;
	localparam logic [DAY_W-1:0]    THR_DAY_RST    = 5'd27;
	localparam logic [HOUR_W-1:0]   THR_HOUR_RST   = 5'd0;
	localparam logic [MINUTE_W-1:0] THR_MINUTE_RST = 6'd0;
	localparam logic [SECOND_W-1:0] THR_SECOND_RST = 6'd0;

	typedef struct packed {
		logic              fmt_ok;
		logic [YACC_W-1:0] year;
		logic [ACC_W-1:0]  month;
		logic [ACC_W-1:0]  day;
		logic [ACC_W-1:0]  hour;
		logic [ACC_W-1:0]  minute;
		logic [ACC_W-1:0]  second;
	} itsp_snap_t;

	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
	} itsp_thr_t;

	function automatic logic [DAY_W-1:0] month_length(input logic leap,
		input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// ----- sv/itsp_parse.sv -----
// ----------------------------------------------------------------------------
// itsp_parse
// Character stage: checks each character against the fixed form, folds
// digits into the field accumulators and hands a snapshot on the last one.
// ----------------------------------------------------------------------------
module itsp_parse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [itsp_pkg::CHAR_W-1:0]   text_char,
	input  logic                          end_of_text,
	input  logic                          adv,
	output logic                          snap_valid_s1,
	output itsp_pkg::itsp_snap_t          snap_s1
);

	logic [itsp_pkg::POS_W-1:0]  pos_q, pos_d;
	logic                        err_q, err_d;
	logic [itsp_pkg::YACC_W-1:0] year_q, year_d;
	logic [itsp_pkg::ACC_W-1:0]  month_q, month_d, day_q, day_d, hour_q, hour_d;
	logic [itsp_pkg::ACC_W-1:0]  minute_q, minute_d, second_q, second_d;
	logic                        accept;
	logic                        digit;
	logic [3:0]                  dval;

	assign in_ready = !snap_valid_s1 || adv;
	assign accept   = in_valid && in_ready;
	assign digit    = (text_char >= itsp_pkg::CH_ZERO) && (text_char <= itsp_pkg::CH_NINE);
	assign dval     = text_char[3:0];

	always_comb begin
		pos_d    = pos_q;
		err_d    = err_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		if (pos_q < itsp_pkg::TS_LEN) begin
			pos_d = pos_q + 5'd1;
		end
		if (pos_q >= itsp_pkg::TS_LEN) begin
			err_d = 1'b1;
		end else if (pos_q == itsp_pkg::POS_DASH_A || pos_q == itsp_pkg::POS_DASH_B) begin
			if (text_char != itsp_pkg::CH_DASH) err_d = 1'b1;
		end else if (pos_q == itsp_pkg::POS_T) begin
			if (text_char != itsp_pkg::CH_T) err_d = 1'b1;
		end else if (pos_q == itsp_pkg::POS_COLON_A || pos_q == itsp_pkg::POS_COLON_B) begin
			if (text_char != itsp_pkg::CH_COLON) err_d = 1'b1;
		end else if (pos_q == itsp_pkg::POS_Z) begin
			if (text_char != itsp_pkg::CH_Z) err_d = 1'b1;
		end else if (!digit) begin
			err_d = 1'b1;
		end else if (pos_q inside {[5'd0:5'd3]}) begin
			year_d = year_q * 14'd10 + {10'd0, dval};
		end else if (pos_q inside {[5'd5:5'd6]}) begin
			month_d = month_q * 7'd10 + {3'd0, dval};
		end else if (pos_q inside {[5'd8:5'd9]}) begin
			day_d = day_q * 7'd10 + {3'd0, dval};
		end else if (pos_q inside {[5'd11:5'd12]}) begin
			hour_d = hour_q * 7'd10 + {3'd0, dval};
		end else if (pos_q inside {[5'd14:5'd15]}) begin
			minute_d = minute_q * 7'd10 + {3'd0, dval};
		end else begin
			second_d = second_q * 7'd10 + {3'd0, dval};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			err_q    <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				pos_q    <= '0;
				err_q    <= 1'b0;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
			end else begin
				pos_q    <= pos_d;
				err_q    <= err_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (accept && end_of_text) begin
			snap_valid_s1 <= 1'b1;
		end else if (adv) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && end_of_text) begin
			snap_s1.fmt_ok <= !err_d && (pos_q == itsp_pkg::POS_LAST);
			snap_s1.year   <= year_d;
			snap_s1.month  <= month_d;
			snap_s1.day    <= day_d;
			snap_s1.hour   <= hour_d;
			snap_s1.minute <= minute_d;
			snap_s1.second <= second_d;
		end
	end

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= itsp_pkg::TS_LEN)
		else $error("character position past end of form");

	a_snap_held: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid_s1 && !adv |=> snap_valid_s1 && $stable(snap_s1))
		else $error("pending snapshot lost or changed");

	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(pos_q) && $stable(err_q) && $stable(year_q))
		else $error("parse state moved without a character");

endmodule

// ----- sv/itsp_check.sv -----
// ----------------------------------------------------------------------------
// itsp_check
// Result stage: range and calendar checks, threshold compare, sync flag
// and the output word register.
// ----------------------------------------------------------------------------
module itsp_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            snap_valid_s1,
	input  itsp_pkg::itsp_snap_t            snap_s1,
	input  itsp_pkg::itsp_thr_t             thr,
	output logic                            adv,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            valid_res,
	output logic [itsp_pkg::YEAR_W-1:0]     out_year,
	output logic [itsp_pkg::MONTH_W-1:0]    out_month,
	output logic [itsp_pkg::DAY_W-1:0]      out_day,
	output logic [itsp_pkg::HOUR_W-1:0]     out_hour,
	output logic [itsp_pkg::MINUTE_W-1:0]   out_minute,
	output logic [itsp_pkg::SECOND_W-1:0]   out_second,
	output logic                            synchronized
);

	logic                           out_valid_s2;
	logic                           valid_res_s2;
	logic [itsp_pkg::YEAR_W-1:0]    out_year_s2;
	logic [itsp_pkg::MONTH_W-1:0]   out_month_s2;
	logic [itsp_pkg::DAY_W-1:0]     out_day_s2;
	logic [itsp_pkg::HOUR_W-1:0]    out_hour_s2;
	logic [itsp_pkg::MINUTE_W-1:0]  out_minute_s2;
	logic [itsp_pkg::SECOND_W-1:0]  out_second_s2;
	logic                           synchronized_s2;
	logic                           sync_q;
	logic                           load;
	logic                           leap;
	logic [itsp_pkg::DAY_W-1:0]     mlen;
	logic                           ok;
	logic                           at_or_after;
	logic                           sync_d;

	assign adv  = !out_valid_s2 || out_ready;
	assign load = snap_valid_s1 && adv;

	// inside 2000..2099 a year is leap exactly when divisible by four
	assign leap = (snap_s1.year[1:0] == 2'b00);
	assign mlen = itsp_pkg::month_length(leap, snap_s1.month[itsp_pkg::MONTH_W-1:0]);

	assign ok = snap_s1.fmt_ok
		&& (snap_s1.year >= itsp_pkg::YEAR_MIN) && (snap_s1.year <= itsp_pkg::YEAR_MAX)
		&& (snap_s1.month >= 7'd1) && (snap_s1.month <= itsp_pkg::MONTH_MAX)
		&& (snap_s1.day >= 7'd1) && (snap_s1.day <= {2'd0, mlen})
		&& (snap_s1.hour <= itsp_pkg::HOUR_MAX)
		&& (snap_s1.minute <= itsp_pkg::MINSEC_MAX)
		&& (snap_s1.second <= itsp_pkg::MINSEC_MAX);

	assign at_or_after =
		{snap_s1.year, snap_s1.month, snap_s1.day,
		 snap_s1.hour, snap_s1.minute, snap_s1.second} >=
		{2'd0, thr.year, 3'd0, thr.month, 2'd0, thr.day,
		 2'd0, thr.hour, 1'd0, thr.minute, 1'd0, thr.second};

	assign sync_d = ok ? at_or_after : sync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
			sync_q       <= 1'b0;
		end else if (load) begin
			out_valid_s2 <= 1'b1;
			sync_q       <= sync_d;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			valid_res_s2    <= ok;
			out_year_s2     <= ok ? snap_s1.year[itsp_pkg::YEAR_W-1:0] : '0;
			out_month_s2    <= ok ? snap_s1.month[itsp_pkg::MONTH_W-1:0] : '0;
			out_day_s2      <= ok ? snap_s1.day[itsp_pkg::DAY_W-1:0] : '0;
			out_hour_s2     <= ok ? snap_s1.hour[itsp_pkg::HOUR_W-1:0] : '0;
			out_minute_s2   <= ok ? snap_s1.minute[itsp_pkg::MINUTE_W-1:0] : '0;
			out_second_s2   <= ok ? snap_s1.second[itsp_pkg::SECOND_W-1:0] : '0;
			synchronized_s2 <= sync_d;
		end
	end

	assign out_valid    = out_valid_s2;
	assign valid_res    = valid_res_s2;
	assign out_year     = out_year_s2;
	assign out_month    = out_month_s2;
	assign out_day      = out_day_s2;
	assign out_hour     = out_hour_s2;
	assign out_minute   = out_minute_s2;
	assign out_second   = out_second_s2;
	assign synchronized = synchronized_s2;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !valid_res_s2 |-> out_year_s2 == '0 && out_month_s2 == '0
			&& out_day_s2 == '0 && out_hour_s2 == '0 && out_minute_s2 == '0
			&& out_second_s2 == '0)
		else $error("invalid word carries nonzero fields");

	a_valid_month: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && valid_res_s2 |-> out_month_s2 >= 4'd1 && out_month_s2 <= 4'd12
			&& out_day_s2 >= 5'd1)
		else $error("valid word with month or day out of range");

	a_sync_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!(load && ok) |=> sync_q == $past(sync_q))
		else $error("sync flag moved without a valid timestamp");

	a_sync_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> synchronized_s2 == sync_q)
		else $error("shown sync flag differs from held flag");

endmodule

// ----- sv/iso_timestamp_parse_validate.sv -----
// ----------------------------------------------------------------------------
// iso_timestamp_parse_validate
// Parses YYYY-MM-DDTHH:MM:SSZ one character per word and returns one
// checked result word per string, with the synchronized flag.
// ----------------------------------------------------------------------------
// result path: the last character loads the snapshot register, then the output word register
// throughput: one character per cycle while in_ready is high; a held snapshot and a stalled output drop it
// characters of the next string are taken while the last result waits in the output register
// reset: parse state, sync flag and output valid cleared, thresholds to defaults
module iso_timestamp_parse_validate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [itsp_pkg::CHAR_W-1:0]       text_char,
	input  logic                              end_of_text,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              valid_res,
	output logic [itsp_pkg::YEAR_W-1:0]       out_year,
	output logic [itsp_pkg::MONTH_W-1:0]      out_month,
	output logic [itsp_pkg::DAY_W-1:0]        out_day,
	output logic [itsp_pkg::HOUR_W-1:0]       out_hour,
	output logic [itsp_pkg::MINUTE_W-1:0]     out_minute,
	output logic [itsp_pkg::SECOND_W-1:0]     out_second,
	output logic                              synchronized,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [itsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [itsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	itsp_pkg::itsp_thr_t  thr_q;
	itsp_pkg::itsp_snap_t snap_s1;
	logic                 snap_valid_s1;
	logic                 adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.year   <= itsp_pkg::THR_YEAR_RST;
			thr_q.month  <= itsp_pkg::THR_MONTH_RST;
			thr_q.day    <= itsp_pkg::THR_DAY_RST;
			thr_q.hour   <= itsp_pkg::THR_HOUR_RST;
			thr_q.minute <= itsp_pkg::THR_MINUTE_RST;
			thr_q.second <= itsp_pkg::THR_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				itsp_pkg::REG_YEAR:   thr_q.year   <= cfg_data[itsp_pkg::YEAR_W-1:0];
				itsp_pkg::REG_MONTH:  thr_q.month  <= cfg_data[itsp_pkg::MONTH_W-1:0];
				itsp_pkg::REG_DAY:    thr_q.day    <= cfg_data[itsp_pkg::DAY_W-1:0];
				itsp_pkg::REG_HOUR:   thr_q.hour   <= cfg_data[itsp_pkg::HOUR_W-1:0];
				itsp_pkg::REG_MINUTE: thr_q.minute <= cfg_data[itsp_pkg::MINUTE_W-1:0];
				itsp_pkg::REG_SECOND: thr_q.second <= cfg_data[itsp_pkg::SECOND_W-1:0];
				default: ;
			endcase
		end
	end

	itsp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_char     (text_char),
		.end_of_text   (end_of_text),
		.adv           (adv),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1)
	);

	itsp_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1),
		.thr           (thr_q),
		.adv           (adv),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.valid_res     (valid_res),
		.out_year      (out_year),
		.out_month     (out_month),
		.out_day       (out_day),
		.out_hour      (out_hour),
		.out_minute    (out_minute),
		.out_second    (out_second),
		.synchronized  (synchronized)
	);

endmodule
